FILE: rtl/lei_pkg.sv
// ----------------------------------------------------------------------------
// lei_pkg: shared types and constants for the Lorenz Euler integrator
// Fixed-point formats, register indexes, sequencer states, saturation helper.
// ----------------------------------------------------------------------------
package lei_pkg;

    localparam int FRAC      = 20;   // Q12.20
    localparam int MUL_W     = 34;   // serial multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CNT_W     = 6;
    localparam int ROOT_ITERS = 32;  // one root bit per cycle
    localparam int DIV_ITERS  = 32;  // one quotient bit per cycle
    localparam int NLANES    = 6;

    localparam logic [31:0] RADIUS_BASE = 32'd26214400; // 0.2 * 2^20 * 125
    localparam logic [7:0]  RADIUS_DIV  = 8'd125;

    localparam logic signed [31:0] RST_SIGMA = 32'sd10485760;
    localparam logic signed [31:0] RST_RHO   = 32'sd29360128;
    localparam logic signed [31:0] RST_BETA  = 32'sd2796203;
    localparam logic [30:0]        RST_STEP  = 31'd13981;
    localparam logic signed [31:0] RST_X     = 32'sd10485760;

    // configuration register indexes
    localparam logic [1:0] REG_SIGMA = 2'd0;
    localparam logic [1:0] REG_RHO   = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;
    localparam logic [1:0] REG_STEP  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_MUL_A,
        ST_DERIV,
        ST_LOAD_B,
        ST_MUL_B,
        ST_UPDATE,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } lei_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
        logic signed [31:0] r;
        if (v > 69'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -69'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/lei_sermul.sv
// ----------------------------------------------------------------------------
// lei_sermul: bit-serial signed multiplier
// Shift-add over the multiplier bits, LSB first; MSB weight subtracted.
// ----------------------------------------------------------------------------
module lei_sermul
    import lei_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MUL_W-1:0]       a_reg, b_reg, lo_reg;
    logic [MUL_W:0]         hi_reg;
    logic [MUL_W:0]         addend, sum;
    logic                   last_bit;

    always_comb
    begin
        last_bit = (cnt_reg == CNT_W'(MUL_W - 1));
        if (!b_reg[0])
            addend = '0;
        else if (last_bit)
            addend = -{a_reg[MUL_W-1], a_reg};
        else
            addend = {a_reg[MUL_W-1], a_reg};
        sum       = hi_reg + addend;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_bit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= op_a;
            b_reg  <= op_b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= {1'b0, b_reg[MUL_W-1:1]};
            hi_reg <= {sum[MUL_W], sum[MUL_W:1]};
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = $signed({hi_reg[MUL_W-1:0], lo_reg});

endmodule

FILE: rtl/lorenz_euler_integrator.sv
// ----------------------------------------------------------------------------
// lorenz_euler_integrator: Lorenz system forward-Euler stepper, Q12.20
// Each advance tick runs SUBSTEPS Euler substeps and emits one result each.
// ----------------------------------------------------------------------------
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  tick      | tick_valid/tick_ready, advance   | in
//  result    | res_valid/res_ready, pos_x/y/z,  | out
//            | speed, radius, last              |
//  config    | cfg_we, cfg_index, cfg_data      | in
//
//  Per substep: two product rounds on the bit-serial multiplier lanes, then
//  the one-bit-per-cycle square root and the divide by 125. The tick is taken
//  in the idle state.
//  Reset: config registers take their defaults, position is (10, 0, 0).
//  Stalls: a result sits in the output register; the next substep runs
//  until its own result is ready and then waits for the slot to drain.
//  A tick with advance low is taken in the idle state and yields no transaction.
// ----------------------------------------------------------------------------
module lorenz_euler_integrator
    import lei_pkg::*;
#(
    parameter int SUBSTEPS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_ready,
    input  logic        advance,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [30:0] speed,
    output logic [30:0] radius,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SUB_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

    lei_state_t state_reg, state_next;

    // configuration
    logic signed [31:0] sigma_reg, rho_reg, beta_reg;
    logic [30:0]        step_reg;

    // integrator position
    logic signed [31:0] x_reg, y_reg, z_reg;

    // substep counter and shared iteration counter
    logic [SUB_W-1:0] sub_reg;
    logic [CNT_W-1:0] cnt_reg;

    // derivative and root/divide datapath
    logic signed [31:0] dx_reg, dy_reg, dz_reg;
    logic [63:0]        rad_reg;
    logic [34:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [31:0]        num_reg;
    logic [6:0]         drem_reg;
    logic [31:0]        quo_reg;
    logic [30:0]        speed_hold_reg;

    // output register
    logic               res_valid_reg, res_valid_next;
    logic [31:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic [30:0]        speed_reg, radius_reg;
    logic               last_reg;

    // multiplier lanes
    logic signed [MUL_W-1:0]  op_a [NLANES];
    logic signed [MUL_W-1:0]  op_b [NLANES];
    logic signed [PROD_W-1:0] prod [NLANES];
    logic [NLANES-1:0]        lane_done;
    logic                     mul_start;

    logic tick_take, out_load, res_take, last_sub;

    assign tick_take = tick_valid && tick_ready;
    assign res_take  = res_valid_reg && res_ready;
    assign last_sub  = (sub_reg == SUB_W'(SUBSTEPS - 1));
    assign out_load  = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);
    assign mul_start = (state_reg == ST_LOAD_A) || (state_reg == ST_LOAD_B);

    // ---------------- operand selection ----------------
    logic signed [32:0] diff_yx, diff_rz;
    logic signed [MUL_W-1:0] x_e, y_e, z_e, dx_e, dy_e, dz_e, st_e;

    always_comb
    begin
        diff_yx = $signed({y_reg[31], y_reg}) - $signed({x_reg[31], x_reg});
        diff_rz = $signed({rho_reg[31], rho_reg}) - $signed({z_reg[31], z_reg});
        x_e  = $signed({{2{x_reg[31]}}, x_reg});
        y_e  = $signed({{2{y_reg[31]}}, y_reg});
        z_e  = $signed({{2{z_reg[31]}}, z_reg});
        dx_e = $signed({{2{dx_reg[31]}}, dx_reg});
        dy_e = $signed({{2{dy_reg[31]}}, dy_reg});
        dz_e = $signed({{2{dz_reg[31]}}, dz_reg});
        st_e = $signed({3'b000, step_reg});
        if (state_reg == ST_LOAD_B)
        begin
            op_a[0] = dx_e; op_b[0] = st_e;
            op_a[1] = dy_e; op_b[1] = st_e;
            op_a[2] = dz_e; op_b[2] = st_e;
            op_a[3] = dx_e; op_b[3] = dx_e;
            op_a[4] = dy_e; op_b[4] = dy_e;
            op_a[5] = dz_e; op_b[5] = dz_e;
        end
        else
        begin
            op_a[0] = $signed({{2{sigma_reg[31]}}, sigma_reg});
            op_b[0] = $signed({diff_yx[32], diff_yx});
            op_a[1] = x_e;
            op_b[1] = $signed({diff_rz[32], diff_rz});
            op_a[2] = x_e;  op_b[2] = y_e;
            op_a[3] = $signed({{2{beta_reg[31]}}, beta_reg});
            op_b[3] = z_e;
            op_a[4] = '0;   op_b[4] = '0;
            op_a[5] = '0;   op_b[5] = '0;
        end
    end

    for (genvar g = 0; g < NLANES; g++)
    begin : g_lane
        lei_sermul u_mul (
            .clk   (clk),
            .rst_n (rst_n),
            .start (mul_start),
            .op_a  (op_a[g]),
            .op_b  (op_b[g]),
            .done  (lane_done[g]),
            .prod  (prod[g])
        );
    end

    // ---------------- derivative and update arithmetic ----------------
    logic signed [68:0] p0, p1, p2, p3, t_dx, t_dy, t_dz, u_x, u_y, u_z;
    logic [63:0]        sq_sum;

    always_comb
    begin
        p0   = $signed({prod[0][PROD_W-1], prod[0]});
        p1   = $signed({prod[1][PROD_W-1], prod[1]});
        p2   = $signed({prod[2][PROD_W-1], prod[2]});
        p3   = $signed({prod[3][PROD_W-1], prod[3]});
        t_dx = p0 >>> FRAC;
        t_dy = (p1 >>> FRAC) - $signed({{37{y_reg[31]}}, y_reg});
        t_dz = (p2 - p3) >>> FRAC;
        u_x  = $signed({{37{x_reg[31]}}, x_reg}) + (p0 >>> FRAC);
        u_y  = $signed({{37{y_reg[31]}}, y_reg}) + (p1 >>> FRAC);
        u_z  = $signed({{37{z_reg[31]}}, z_reg}) + (p2 >>> FRAC);
        sq_sum = prod[3][63:0] + prod[4][63:0] + prod[5][63:0];
    end

    // ---------------- root and divide steps ----------------
    logic [36:0] rem_t, trial;
    logic        root_ge;
    logic [7:0]  drem_t;
    logic        div_ge;

    always_comb
    begin
        rem_t   = {rem_reg, rad_reg[63:62]};
        trial   = {3'b000, root_reg, 2'b01};
        root_ge = (rem_t >= trial);
        drem_t  = {drem_reg, num_reg[31]};
        div_ge  = (drem_t >= RADIUS_DIV);
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        tick_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid && advance)
                    state_next = ST_LOAD_A;
            end
            ST_LOAD_A:   state_next = ST_MUL_A;
            ST_MUL_A:    if (lane_done[0]) state_next = ST_DERIV;
            ST_DERIV:    state_next = ST_LOAD_B;
            ST_LOAD_B:   state_next = ST_MUL_B;
            ST_MUL_B:    if (lane_done[0]) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == CNT_W'(ROOT_ITERS - 1))
                    state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                    state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = last_sub ? ST_IDLE : ST_LOAD_A;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control, config and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= RST_SIGMA;
            rho_reg       <= RST_RHO;
            beta_reg      <= RST_BETA;
            step_reg      <= RST_STEP;
            x_reg         <= RST_X;
            y_reg         <= '0;
            z_reg         <= '0;
            sub_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIGMA: sigma_reg <= cfg_data;
                    REG_RHO:   rho_reg   <= cfg_data;
                    REG_BETA:  beta_reg  <= cfg_data;
                    REG_STEP:  step_reg  <= cfg_data[30:0];
                    default:   ;
                endcase
            end
            if (state_reg == ST_UPDATE)
            begin
                x_reg <= sat32(u_x);
                y_reg <= sat32(u_y);
                z_reg <= sat32(u_z);
            end
            if (tick_take)
                sub_reg <= '0;
            else if (out_load && !last_sub)
                sub_reg <= sub_reg + SUB_W'(1);
            if (state_reg == ST_UPDATE || state_reg == ST_DIV_INIT)
                cnt_reg <= '0;
            else if (state_reg == ST_SQRT || state_reg == ST_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
            res_valid_next = 1'b1;
        else if (res_take)
            res_valid_next = 1'b0;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DERIV)
        begin
            dx_reg <= sat32(t_dx);
            dy_reg <= sat32(t_dy);
            dz_reg <= sat32(t_dz);
        end
        if (state_reg == ST_UPDATE)
        begin
            rad_reg  <= sq_sum;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= root_ge ? 35'(rem_t - trial) : rem_t[34:0];
            root_reg <= {root_reg[30:0], root_ge};
        end
        if (state_reg == ST_DIV_INIT)
        begin
            // clamp root to 31 bits, then divide (base + speed) by 125
            speed_hold_reg <= root_reg[31] ? 31'h7FFFFFFF : root_reg[30:0];
            num_reg  <= RADIUS_BASE
                        + {1'b0, (root_reg[31] ? 31'h7FFFFFFF : root_reg[30:0])};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            num_reg  <= {num_reg[30:0], 1'b0};
            drem_reg <= div_ge ? 7'(drem_t - RADIUS_DIV) : drem_t[6:0];
            quo_reg  <= {quo_reg[30:0], div_ge};
        end
        if (out_load)
        begin
            pos_x_reg  <= x_reg;
            pos_y_reg  <= y_reg;
            pos_z_reg  <= z_reg;
            speed_reg  <= speed_hold_reg;
            radius_reg <= quo_reg[30:0];
            last_reg   <= last_sub;
        end
    end

    assign res_valid = res_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign speed     = speed_reg;
    assign radius    = radius_reg;
    assign last      = last_reg;

    // ---------------- assertions ----------------
    // all lanes start together, so they must finish together
    a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> (lane_done == {NLANES{1'b1}}))
        else $error("multiplier lanes out of step");

    // radius never drops below the 0.2 floor
    a_radius_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (radius_reg >= 31'd209715))
        else $error("radius below base");

    // an advance tick starts a substep on the next cycle
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_take && advance) |=> (state_reg == ST_LOAD_A))
        else $error("advance tick not started");

    // ticks are only taken with no substep in flight
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |-> (sub_reg == '0 || state_reg == ST_IDLE) && !mul_start)
        else $error("tick taken mid frame");

endmodule

FILE: bench/lorenz_euler_integrator_tb.sv
// ----------------------------------------------------------------------------
// lorenz_euler_integrator_tb: self-checking bench for the Lorenz Euler stepper
// Drives advance ticks and register writes, predicts every substep result in
// Q12.20 and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module lorenz_euler_integrator_tb;
    import lei_pkg::*;

    localparam int N_SUB      = 5;
    localparam int WDOG_LIMIT = 40000;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [30:0] spd;
        logic [30:0] rad;
        logic        fin;
    } substep_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tick_valid = 1'b0;
    logic        tick_ready;
    logic        advance = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [30:0] speed, radius;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SIGMA;
    logic [31:0] cfg_data = '0;

    // predictor copy of registers and position
    logic signed [63:0] m_sigma, m_rho, m_beta, m_x, m_y, m_z;
    logic [63:0]        m_step;

    substep_t substep_q[$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  wdog = 0;

    lorenz_euler_integrator #(.SUBSTEPS(N_SUB)) dut (.*);

    always #5 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic logic signed [63:0] floor_q20(input logic signed [63:0] v);
        return v >>> FRAC;  // arithmetic shift floors toward minus infinity
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] n);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // run one frame of Euler substeps, queue each expected result
    task automatic predict_frame();
        logic signed [63:0] x, y, z, dx, dy, dz, st;
        logic [63:0] sq, spd, rad;
        substep_t e;
        for (int k = 0; k < N_SUB; k++)
        begin
            x = m_x; y = m_y; z = m_z;
            st = $signed(m_step);
            dx = clip32(floor_q20(m_sigma * (y - x)));
            dy = clip32(floor_q20(x * (m_rho - z)) - y);
            dz = clip32(floor_q20(x * y - m_beta * z));
            m_x = clip32(x + floor_q20(dx * st));
            m_y = clip32(y + floor_q20(dy * st));
            m_z = clip32(z + floor_q20(dz * st));
            sq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
            spd = int_root(sq);
            if (spd > 64'h7FFFFFFF) spd = 64'h7FFFFFFF;
            rad = (64'(RADIUS_BASE) + spd) / 64'(RADIUS_DIV);
            e.px = m_x[31:0];
            e.py = m_y[31:0];
            e.pz = m_z[31:0];
            e.spd = spd[30:0];
            e.rad = rad[30:0];
            e.fin = (k == N_SUB - 1);
            substep_q.push_back(e);
        end
    endtask

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        substep_t e;
        if (res_valid && res_ready)
        begin
            if (substep_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction x=%h", pos_x);
            end
            else
            begin
                e = substep_q.pop_front();
                if (e.px !== pos_x || e.py !== pos_y || e.pz !== pos_z ||
                    e.spd !== speed || e.rad !== radius || e.fin !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp x=%h y=%h z=%h s=%h r=%h l=%b",
                                  " got x=%h y=%h z=%h s=%h r=%h l=%b"},
                                 e.px, e.py, e.pz, e.spd, e.rad, e.fin,
                                 pos_x, pos_y, pos_z, speed, radius, last);
                end
            end
        end
    end

    // receiver: random stalls, or a long counted hold-off
    always @(posedge clk)
    begin
        if (recv_hold)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((tick_valid && tick_ready) || (res_valid && res_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- driver tasks ----------------
    task automatic send_tick(input logic adv);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        tick_valid <= 1'b1;
        advance <= adv;
        @(posedge clk);
        while (!tick_ready) @(posedge clk);
        if (adv) predict_frame();
        tick_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (substep_q.size() != 0) @(posedge clk);
        // a bare tick starts no substep, so the extra wait is a safety margin
        repeat (800) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_SIGMA: m_sigma = $signed(val);
            REG_RHO:   m_rho = $signed(val);
            REG_BETA:  m_beta = $signed(val);
            default:   m_step = {33'd0, val[30:0]};
        endcase
    endtask

    task automatic set_coeffs(input logic [31:0] s, input logic [31:0] r,
                              input logic [31:0] b, input logic [31:0] st);
        drain();
        write_reg(REG_SIGMA, s);
        write_reg(REG_RHO, r);
        write_reg(REG_BETA, b);
        write_reg(REG_STEP, st);
        cfg_we <= 1'b0;
    endtask

    // ---------------- tests ----------------
    task automatic test_defaults();
        send_tick(1'b1);
        send_tick(1'b0);   // idle tick: no results, position held
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // large values push the position into saturation; then small and zero steps
    task automatic test_extremes();
        set_coeffs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        repeat (4) send_tick(1'b1);
        set_coeffs(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        repeat (4) send_tick(1'b1);
        set_coeffs(32'hFFFFFFFF, 32'h00000000, 32'h00000001, 32'h00000000);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        set_coeffs(32'h00A00000, 32'h01C00000, 32'h002AAAAB, 32'h00000001);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 39)
            begin
                // mostly sane Lorenz ranges, sometimes fully random bits
                if ($urandom_range(3) == 0)
                    set_coeffs($urandom, $urandom, $urandom, $urandom);
                else
                    set_coeffs($urandom_range(20 << 20), $urandom_range(50 << 20),
                               $urandom_range(5 << 20), $urandom_range(1 << 16));
            end
            send_tick($urandom_range(9) != 0);
        end
    endtask

    // receiver stops for a long stretch while ticks keep coming
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            repeat (6) send_tick(1'b1);
            begin
                repeat (3000) @(posedge clk);
                recv_hold = 1'b0;
            end
        join
    endtask

    initial
    begin
        m_sigma = RST_SIGMA; m_rho = RST_RHO; m_beta = RST_BETA;
        m_step = {33'd0, RST_STEP};
        m_x = RST_X; m_y = 0; m_z = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        send_idle_pct = 38; recv_idle_pct = 87;
        test_extremes();
        test_random(130);
        send_idle_pct = 87; recv_idle_pct = 38;
        test_random(130);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(130);

        while (substep_q.size() != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
